// File: sv/frustum_aabb_cull_assert.svh
// assertion macros for the frustum box culler
// expects clk and rst in the scope of each use; no other dependencies
`ifndef FRUSTUM_AABB_CULL_ASSERT_SVH
`define FRUSTUM_AABB_CULL_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked at every rising edge outside reset
`define FAC_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("frustum_aabb_cull assertion failed");
// next-cycle implication
`define FAC_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("frustum_aabb_cull assertion failed");
`else
`define FAC_ASSERT_IMPL(label, pre, post)
`define FAC_ASSERT_NEXT(label, pre, post)
`endif

`endif

// File: sv/fac_pkg.sv
// shared widths, types and constants of the frustum box culler
// no dependencies
package fac_pkg;

  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_IDX_W     = $clog2(NUM_REGS);
  localparam int unsigned ADDR_W        = REG_IDX_W + 3;
  localparam int unsigned CFG_W         = 64;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned NUM_ENTRIES   = 16;
  localparam int unsigned NUM_PLANES    = 6;
  localparam int unsigned NUM_AXES      = 3;
  localparam int unsigned NUM_COLS      = 4;
  localparam int unsigned COEF_W        = COORD_W + 1;
  localparam int unsigned PROD_W        = COEF_W + COORD_W;
  localparam int unsigned PSUM_W        = PROD_W + 1;
  localparam int unsigned SUM_W         = PSUM_W + 1;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // planes that add the matrix row to row 3 (bit per plane), the others subtract
  localparam logic [NUM_PLANES-1:0] PLANE_PLUS = 6'b100110;

  typedef logic [CFG_W-1:0]          cfg_word_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // identity matrix in column-major register pairs
  localparam cfg_word_t MATRIX_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

endpackage

// File: sv/fac_if.sv
// valid/ready channel interfaces of the frustum box culler: box in, verdict out
// depends on fac_pkg
interface fac_box_if import fac_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface fac_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// File: sv/frustum_aabb_cull.sv
// frustum box culler: one box per cycle sustained unless vis.ready stalls;
// each of the five stages holds one item and
// moves on when the stage after it is empty or moving, so bubbles collapse
// rst (synchronous) clears all stage valid bits and loads the identity matrix
// a matrix write reaches the plane coefficients through the matrix and coef registers
// depends on fac_pkg, fac_if.sv and frustum_aabb_cull_assert.svh
`include "frustum_aabb_cull_assert.svh"

module frustum_aabb_cull import fac_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready,
  // box items in, verdict items out
  fac_box_if.sink           box,
  fac_vis_if.source         vis
);

  // ---------------------------------------------------------------
  // matrix registers, eight column-major entry pairs
  // ---------------------------------------------------------------
  cfg_word_t matrix [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = matrix[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix <= MATRIX_RESET;
    end else if (cfg_wr) begin
      matrix[reg_idx] <= pwdata;
    end
  end

  // ---------------------------------------------------------------
  // plane coefficients: row 3 plus or minus row 0, 1, 2
  // entry (row r, col c) sits at index 4*c + r
  // registered so the adders stay off the multiplier path
  // ---------------------------------------------------------------
  coord_t ent [NUM_ENTRIES];
  coef_t  coef_next [NUM_PLANES][NUM_COLS];
  coef_t  coef [NUM_PLANES][NUM_COLS];

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_ent
    assign ent[i] = matrix[i >> 1][(i & 1) * COORD_W +: COORD_W];
  end

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    for (genvar k = 0; k < NUM_COLS; k++) begin : g_col
      if (PLANE_PLUS[p]) begin : g_add
        assign coef_next[p][k] = COEF_W'(ent[4*k + 3]) + COEF_W'(ent[4*k + (p >> 1)]);
      end else begin : g_sub
        assign coef_next[p][k] = COEF_W'(ent[4*k + 3]) - COEF_W'(ent[4*k + (p >> 1)]);
      end
    end
  end

  always_ff @(posedge clk) begin
    coef <= coef_next;
  end

  // ---------------------------------------------------------------
  // pipeline handshake: each stage loads when empty or draining
  // ---------------------------------------------------------------
  logic v0, v1, v2, v3, v4;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic [4:0] vld;
  logic in_fire, out_fire;

  assign rdy4      = !v4 || vis.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign box.ready = rdy0;
  assign vis.valid = v4;
  assign vld       = {v4, v3, v2, v1, v0};
  assign in_fire   = box.valid && box.ready;
  assign out_fire  = vis.valid && vis.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy0) v0 <= box.valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------
  // stage 0: box corners registered
  // ---------------------------------------------------------------
  coord_t box_lo [NUM_AXES];
  coord_t box_hi [NUM_AXES];

  always_ff @(posedge clk) begin
    if (box.valid && rdy0) begin
      box_lo[0] <= box.box_min_x;
      box_lo[1] <= box.box_min_y;
      box_lo[2] <= box.box_min_z;
      box_hi[0] <= box.box_max_x;
      box_hi[1] <= box.box_max_y;
      box_hi[2] <= box.box_max_z;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: exact 33x32 products, plane coefficient times each corner
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_lo [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0] prod_hi [NUM_PLANES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (v0 && rdy1) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          prod_lo[p][k] <= PROD_W'(coef[p][k]) * PROD_W'(box_lo[k]);
          prod_hi[p][k] <= PROD_W'(coef[p][k]) * PROD_W'(box_hi[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 2: per axis the larger product picks the best corner
  // (min and max are not swapped for an inverted box)
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] best [NUM_PLANES][NUM_AXES];

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          best[p][k] <= (prod_lo[p][k] < prod_hi[p][k]) ? prod_hi[p][k] : prod_lo[p][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 3: partial sums, x + y and z + d scaled to the product point
  // ---------------------------------------------------------------
  logic signed [PSUM_W-1:0] psum_a [NUM_PLANES];
  logic signed [PSUM_W-1:0] psum_b [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        psum_a[p] <= PSUM_W'(best[p][0]) + PSUM_W'(best[p][1]);
        psum_b[p] <= PSUM_W'(best[p][2]) + (PSUM_W'(coef[p][NUM_COLS-1]) <<< FRAC_BITS);
      end
    end
  end

  // ---------------------------------------------------------------
  // stage 4: output register, box is visible when every plane sum is
  // strictly positive (an all-zero plane rejects everything)
  // ---------------------------------------------------------------
  logic signed [SUM_W-1:0] total [NUM_PLANES];
  logic [NUM_PLANES-1:0] pass;

  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      total[p] = SUM_W'(psum_a[p]) + SUM_W'(psum_b[p]);
      pass[p]  = !total[p][SUM_W-1] && (|total[p]);
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && rdy4) begin
      vis.visible <= &pass;
    end
  end

  // ---------------------------------------------------------------
  // checks: item count in the pipe tracks accepts and deliveries
  // ---------------------------------------------------------------
  `FAC_ASSERT_NEXT(a_count_up, in_fire && !out_fire, $countones(vld) == $countones($past(vld)) + 1)
  `FAC_ASSERT_NEXT(a_count_down, out_fire && !in_fire, $countones(vld) + 1 == $countones($past(vld)))
  `FAC_ASSERT_IMPL(a_full_stall, (&vld) && !vis.ready, !box.ready)

endmodule
